// File: design/gmt_pkg.sv
// Shared types, constants and the triangle keep rule for the grid mesh triangulator.
package gmt_pkg;

    localparam int IDX_W            = 16;
    localparam int NUM_W            = 32;
    localparam int CFG_W            = 11;
    localparam int MAX_ROW_LEN_DEF  = 1024;
    localparam int TRI_PER_ITEM     = 4;
    localparam int TRI_CNT_W        = $clog2(TRI_PER_ITEM + 1);
    localparam int TRI_SEL_W        = $clog2(TRI_PER_ITEM);

    typedef logic signed [IDX_W-1:0] t_idx;

    // input request payload
    typedef struct packed {
        t_idx vertex_index;
        logic start_grid;
    } t_in_item;

    // result payload
    typedef struct packed {
        t_idx             corner_a;
        t_idx             corner_b;
        t_idx             corner_c;
        logic [NUM_W-1:0] triangle_number;
        logic             last_of_run;
    } t_out_item;

    // per-item control carried from the column tracker to the emitter
    typedef struct packed {
        logic left_cell;   // cell c-1 is emitted
        logic wrap_cell;   // wrap-around cell is emitted (row end)
        logic col_odd;     // column parity, selects the line buffer bank
        logic col_one;     // column 1: prev[c-1] comes from the column-0 register
        logic col_zero;    // column 0: prev[c] comes from the column-0 register
        logic start;       // first entry of a new grid
    } t_stage_ctl;

    typedef struct packed {
        t_idx       cur;        // current entry
        t_idx       held;       // previous entry of this row
        t_idx       row_first;  // entry at column 0 of this row
        t_idx       prev0;      // column 0 of the previous row
        t_stage_ctl ctl;
    } t_stage;

    // distinct, nonzero, even number of negatives
    function automatic logic keep_tri(t_idx a, t_idx b, t_idx c);
        logic distinct;
        logic nonzero;
        distinct = (a != b) && (a != c) && (b != c);
        nonzero  = (a != '0) && (b != '0) && (c != '0);
        return distinct && nonzero && !(a[IDX_W-1] ^ b[IDX_W-1] ^ c[IDX_W-1]);
    endfunction

endpackage

// File: design/gmt_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
module gmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word when the same address is written
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/gmt_front.sv
// Column tracker: row length register, row state, line buffer addressing and stage register.
module gmt_front #(
    parameter int MAX_ROW_LENGTH = gmt_pkg::MAX_ROW_LEN_DEF,
    parameter int BANK_AW        = 9
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gmt_pkg::CFG_W-1:0]      i_cfg_data,
    // input requests
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  gmt_pkg::t_in_item              i_in_item,
    // line buffer banks, index 0 even columns, index 1 odd columns
    output logic                           o_ram_we    [2],
    output logic [BANK_AW-1:0]             o_ram_waddr [2],
    output logic [gmt_pkg::IDX_W-1:0]      o_ram_wdata [2],
    output logic                           o_ram_re,
    output logic [BANK_AW-1:0]             o_ram_raddr [2],
    // stage toward the emitter
    output logic                           o_stage_valid,
    output gmt_pkg::t_stage                o_stage,
    input  logic                           i_stage_ready
);

    localparam int COL_W = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1);
    localparam int CMP_W = (LEN_W > gmt_pkg::CFG_W) ? LEN_W : gmt_pkg::CFG_W;

    logic [gmt_pkg::CFG_W-1:0] r_row_length;
    logic [COL_W-1:0]          r_col;
    logic                      r_first_row;
    gmt_pkg::t_idx             r_held;
    gmt_pkg::t_idx             r_row_first;
    gmt_pkg::t_idx             r_prev0;
    logic                      r_stage_valid;
    gmt_pkg::t_stage           r_stage;

    logic                      accept;
    logic [CMP_W-1:0]          len_ext;
    logic [CMP_W-1:0]          max_ext;
    logic [CMP_W-1:0]          cols;
    logic [COL_W-1:0]          last_col;
    logic [COL_W-1:0]          col_in;
    logic [COL_W-1:0]          col;
    logic [COL_W-1:0]          col_m1;
    logic [COL_W-1:0]          even_idx;
    logic [COL_W-1:0]          odd_idx;
    logic                      last;
    logic                      first_row;
    logic                      wr_held;
    logic                      wr_last;
    gmt_pkg::t_idx             cur;
    gmt_pkg::t_idx             row_first;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_stage_valid || i_stage_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign cur         = i_in_item.vertex_index;

    // effective row length, clamped to 1..MAX, and the column of this entry
    always_comb begin
        len_ext   = CMP_W'(r_row_length);
        max_ext   = CMP_W'(MAX_ROW_LENGTH);
        if (len_ext == '0) begin
            cols = CMP_W'(1);
        end else if (len_ext > max_ext) begin
            cols = max_ext;
        end else begin
            cols = len_ext;
        end
        last_col  = COL_W'(cols - CMP_W'(1));
        col_in    = i_in_item.start_grid ? '0 : r_col;
        col       = (CMP_W'(col_in) >= cols) ? last_col : col_in;
        last      = (col == last_col);
        first_row = i_in_item.start_grid || r_first_row;
        row_first = (col == '0) ? cur : r_row_first;
        col_m1    = (col == '0) ? COL_W'(1) : col - COL_W'(1);
        even_idx  = col[0] ? col_m1 : col;
        odd_idx   = col[0] ? col : col_m1;
        wr_held   = (col > COL_W'(1));
        wr_last   = last && (col != '0);
    end

    // delayed line buffer writes: c-1 gets the held entry, row end stores the last column
    always_comb begin
        o_ram_re       = accept;
        o_ram_raddr[0] = BANK_AW'(even_idx >> 1);
        o_ram_raddr[1] = BANK_AW'(odd_idx >> 1);

        o_ram_we[0]    = 1'b0;
        o_ram_waddr[0] = BANK_AW'(col >> 1);
        o_ram_wdata[0] = cur;
        if (wr_held && col[0]) begin
            o_ram_we[0]    = accept;
            o_ram_waddr[0] = BANK_AW'(col_m1 >> 1);
            o_ram_wdata[0] = r_held;
        end else if (wr_last && !col[0]) begin
            o_ram_we[0]    = accept;
        end

        o_ram_we[1]    = 1'b0;
        o_ram_waddr[1] = BANK_AW'(col >> 1);
        o_ram_wdata[1] = cur;
        if (wr_held && !col[0]) begin
            o_ram_we[1]    = accept;
            o_ram_waddr[1] = BANK_AW'(col_m1 >> 1);
            o_ram_wdata[1] = r_held;
        end else if (wr_last && col[0]) begin
            o_ram_we[1]    = accept;
        end
    end

    // row state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length  <= gmt_pkg::CFG_W'(1);
            r_col         <= '0;
            r_first_row   <= 1'b1;
            r_held        <= '0;
            r_row_first   <= '0;
            r_stage_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_row_length <= i_cfg_data;
            end
            if (accept) begin
                r_col         <= last ? '0 : col + COL_W'(1);
                r_first_row   <= first_row && !last;
                r_held        <= cur;
                r_row_first   <= row_first;
                r_stage_valid <= 1'b1;
            end else if (i_stage_ready) begin
                r_stage_valid <= 1'b0;
            end
        end
    end

    // column 0 of the previous row and the stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (last) begin
                r_prev0 <= row_first;
            end
            r_stage.cur           <= cur;
            r_stage.held          <= r_held;
            r_stage.row_first     <= row_first;
            r_stage.prev0         <= r_prev0;
            r_stage.ctl.left_cell <= !first_row && (col != '0);
            r_stage.ctl.wrap_cell <= !first_row && last;
            r_stage.ctl.col_odd   <= col[0];
            r_stage.ctl.col_one   <= (col == COL_W'(1));
            r_stage.ctl.col_zero  <= (col == '0);
            r_stage.ctl.start     <= i_in_item.start_grid;
        end
    end

    assign o_stage_valid = r_stage_valid;
    assign o_stage       = r_stage;

endmodule

// File: design/gmt_emit.sv
// Triangle emitter: keep test, running count and the result bank drained one per cycle while the result port is ready.
module gmt_emit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_stage_valid,
    input  gmt_pkg::t_stage                i_stage,
    output logic                           o_stage_ready,
    input  logic [gmt_pkg::IDX_W-1:0]      i_even_data,
    input  logic [gmt_pkg::IDX_W-1:0]      i_odd_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output gmt_pkg::t_out_item             o_out_item
);

    localparam int NUM_W = gmt_pkg::NUM_W;
    localparam int N     = gmt_pkg::TRI_PER_ITEM;

    gmt_pkg::t_out_item              r_res [N];
    logic [gmt_pkg::TRI_CNT_W-1:0]   r_rem;
    logic [gmt_pkg::TRI_SEL_W-1:0]   r_sel;
    logic [NUM_W-1:0]                r_total;

    gmt_pkg::t_out_item              n_res [N];
    logic [NUM_W-1:0]                n_total;

    gmt_pkg::t_idx                   prev_lo;
    gmt_pkg::t_idx                   prev_hi;
    gmt_pkg::t_idx                   ta [N];
    gmt_pkg::t_idx                   tb [N];
    gmt_pkg::t_idx                   tc [N];
    logic [N-1:0]                    keep;
    logic [gmt_pkg::TRI_CNT_W-1:0]   pos;
    logic [NUM_W-1:0]                base;
    logic [NUM_W:0]                  sum;
    logic                            out_fire;
    logic                            load;

    assign out_fire      = o_out_valid && i_out_ready;
    assign o_stage_ready = (r_rem == '0) ||
                           ((r_rem == gmt_pkg::TRI_CNT_W'(1)) && i_out_ready);
    assign load          = i_stage_valid && o_stage_ready;

    // previous-row corners from the two banks or the column-0 register
    always_comb begin
        prev_lo = i_stage.ctl.col_one ? i_stage.prev0 :
                  (i_stage.ctl.col_odd ? $signed(i_even_data) : $signed(i_odd_data));
        prev_hi = i_stage.ctl.col_zero ? i_stage.prev0 :
                  (i_stage.ctl.col_odd ? $signed(i_odd_data) : $signed(i_even_data));
    end

    // candidate triangles in emission order
    always_comb begin
        ta[0] = i_stage.held; tb[0] = prev_lo;       tc[0] = prev_hi;
        ta[1] = i_stage.held; tb[1] = prev_hi;       tc[1] = i_stage.cur;
        ta[2] = i_stage.cur;  tb[2] = prev_hi;       tc[2] = i_stage.prev0;
        ta[3] = i_stage.cur;  tb[3] = i_stage.prev0; tc[3] = i_stage.row_first;
        keep[0] = i_stage.ctl.left_cell && gmt_pkg::keep_tri(ta[0], tb[0], tc[0]);
        keep[1] = i_stage.ctl.left_cell && gmt_pkg::keep_tri(ta[1], tb[1], tc[1]);
        keep[2] = i_stage.ctl.wrap_cell && gmt_pkg::keep_tri(ta[2], tb[2], tc[2]);
        keep[3] = i_stage.ctl.wrap_cell && gmt_pkg::keep_tri(ta[3], tb[3], tc[3]);
    end

    // pack kept triangles and number them, saturating
    always_comb begin
        base = i_stage.ctl.start ? '0 : r_total;
        pos  = '0;
        sum  = '0;
        for (int i = 0; i < N; i++) begin
            n_res[i] = r_res[i];
        end
        for (int i = 0; i < N; i++) begin
            if (keep[i]) begin
                sum = {1'b0, base} + (NUM_W+1)'(pos) + (NUM_W+1)'(1);
                n_res[pos[gmt_pkg::TRI_SEL_W-1:0]].corner_a        = ta[i];
                n_res[pos[gmt_pkg::TRI_SEL_W-1:0]].corner_b        = tb[i];
                n_res[pos[gmt_pkg::TRI_SEL_W-1:0]].corner_c        = tc[i];
                n_res[pos[gmt_pkg::TRI_SEL_W-1:0]].triangle_number =
                    sum[NUM_W] ? '1 : sum[NUM_W-1:0];
                n_res[pos[gmt_pkg::TRI_SEL_W-1:0]].last_of_run     = 1'b0;
                pos = pos + gmt_pkg::TRI_CNT_W'(1);
            end
        end
        sum     = {1'b0, base} + (NUM_W+1)'(pos);
        n_total = sum[NUM_W] ? '1 : sum[NUM_W-1:0];
    end

    // result bank control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_sel   <= '0;
            r_total <= '0;
        end else if (load) begin
            r_rem   <= pos;
            r_sel   <= '0;
            r_total <= n_total;
        end else if (out_fire) begin
            r_rem   <= r_rem - gmt_pkg::TRI_CNT_W'(1);
            r_sel   <= r_sel + gmt_pkg::TRI_SEL_W'(1);
        end
    end

    // result bank payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int i = 0; i < N; i++) begin
                r_res[i] <= n_res[i];
            end
        end
    end

    // current result, flagged on the last one of its item
    always_comb begin
        o_out_valid             = (r_rem != '0);
        o_out_item              = r_res[r_sel];
        o_out_item.last_of_run  = (r_rem == gmt_pkg::TRI_CNT_W'(1));
    end

endmodule

// File: design/grid_mesh_triangulator_core.sv
// Top level of the grid mesh triangulator: column tracker, two line buffer banks, emitter.
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_ready      i_in_item  (vertex_index, start_grid)
//  result    out        o_out_valid / i_out_ready    o_out_item (corners, number, last)
//  config    in         i_cfg_valid / o_cfg_ready    i_cfg_data (row_length)
//
// A request is taken every cycle while the result bank can take the previous one; the
// triangles of an entry pass the stage register and the result bank, then appear one per
// cycle while the result port is ready. The single result port sets the rate: an entry with
// k kept triangles holds it for k results, and an entry with none does not use it.
// Reset is synchronous: row length 1, first row, count zero; the line buffer is not cleared.
// A stalled result port holds the bank, then the stage register, then input ready.
module grid_mesh_triangulator_core #(
    parameter int MAX_ROW_LENGTH = gmt_pkg::MAX_ROW_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gmt_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  gmt_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output gmt_pkg::t_out_item          o_out_item
);

    localparam int BANK_DEPTH = (MAX_ROW_LENGTH + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic                        ram_we    [2];
    logic [BANK_AW-1:0]          ram_waddr [2];
    logic [gmt_pkg::IDX_W-1:0]   ram_wdata [2];
    logic                        ram_re;
    logic [BANK_AW-1:0]          ram_raddr [2];
    logic [gmt_pkg::IDX_W-1:0]   ram_rdata [2];
    logic                        stage_valid;
    logic                        stage_ready;
    gmt_pkg::t_stage             stage;

    gmt_front #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .BANK_AW        (BANK_AW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_item      (i_in_item),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .o_stage_valid  (stage_valid),
        .o_stage        (stage),
        .i_stage_ready  (stage_ready)
    );

    // line buffer: even columns in bank 0, odd columns in bank 1
    for (genvar b = 0; b < 2; b++) begin : g_bank
        gmt_ram #(
            .WIDTH  (gmt_pkg::IDX_W),
            .DEPTH  (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[b]),
            .i_waddr (ram_waddr[b]),
            .i_wdata (ram_wdata[b]),
            .i_re    (ram_re),
            .i_raddr (ram_raddr[b]),
            .o_rdata (ram_rdata[b])
        );
    end

    gmt_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stage_valid  (stage_valid),
        .i_stage        (stage),
        .o_stage_ready  (stage_ready),
        .i_even_data    (ram_rdata[0]),
        .i_odd_data     (ram_rdata[1]),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_item     (o_out_item)
    );

endmodule

// File: bench/grid_mesh_triangulator_core_tb.sv
// Testbench for grid_mesh_triangulator_core: randomized grids checked against a triangle predictor.
`timescale 1ns / 100ps

module grid_mesh_triangulator_core_tb;

    localparam int CFG_W         = gmt_pkg::CFG_W;
    localparam int NUM_W         = gmt_pkg::NUM_W;
    localparam int MAX_COLS      = gmt_pkg::MAX_ROW_LEN_DEF;
    localparam int RANDOM_TARGET = 200;
    localparam int WIDE_ENTRIES  = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;

    // Predicts the triangles of each grid entry and checks them in order
    class triangle_scoreboard;
        logic [CFG_W-1:0]       row_len;
        gmt_pkg::t_idx          prev_row [MAX_COLS];
        gmt_pkg::t_idx          held;
        gmt_pkg::t_idx          row_first;
        int unsigned            col_pos;
        bit                     in_top_row;
        logic [NUM_W-1:0]       tri_total;
        gmt_pkg::t_out_item     expected_triangles[$];
        int unsigned            errors;
        int unsigned            checked;

        function new();
            row_len    = CFG_W'(1);
            held       = '0;
            row_first  = '0;
            col_pos    = 0;
            in_top_row = 1'b1;
            tri_total  = '0;
            errors     = 0;
            checked    = 0;
        endfunction

        // register value 0 acts as 1, anything above the buffer depth saturates
        function int unsigned eff_cols(logic [CFG_W-1:0] len);
            if (len == 0) return 1;
            if (len > MAX_COLS) return MAX_COLS;
            return 32'(len);
        endfunction

        function void set_row_length(logic [CFG_W-1:0] len);
            row_len = len;
        endfunction

        function int unsigned pending();
            return expected_triangles.size();
        endfunction

        // distinct, nonzero, even count of negative corners
        function bit is_kept(gmt_pkg::t_idx a, gmt_pkg::t_idx b, gmt_pkg::t_idx c);
            int negs;
            if (a == b || a == c || b == c) return 1'b0;
            if (a == 0 || b == 0 || c == 0) return 1'b0;
            negs = int'(a < 0) + int'(b < 0) + int'(c < 0);
            return (negs % 2) == 0;
        endfunction

        function void add_triangle(gmt_pkg::t_idx a, gmt_pkg::t_idx b, gmt_pkg::t_idx c);
            gmt_pkg::t_out_item shape;
            if (!is_kept(a, b, c)) return;
            if (tri_total != '1) tri_total++;
            shape.corner_a        = a;
            shape.corner_b        = b;
            shape.corner_c        = c;
            shape.triangle_number = tri_total;
            shape.last_of_run     = 1'b0;
            expected_triangles.insert(expected_triangles.size(), shape);
        endfunction

        // one grid quad gives up to two triangles
        function void add_quad(gmt_pkg::t_idx cur_h, gmt_pkg::t_idx prev_h,
                               gmt_pkg::t_idx prev_n, gmt_pkg::t_idx cur_n);
            add_triangle(cur_h, prev_h, prev_n);
            add_triangle(cur_h, prev_n, cur_n);
        endfunction

        // accepted request: advance the row state and queue its triangles
        function void take_entry(gmt_pkg::t_in_item item);
            gmt_pkg::t_idx v;
            int unsigned   cols;
            int unsigned   c;
            bit            row_end;
            int            base;
            v    = item.vertex_index;
            base = expected_triangles.size();
            if (item.start_grid) begin
                col_pos    = 0;
                in_top_row = 1'b1;
                tri_total  = '0;
            end
            cols    = eff_cols(row_len);
            c       = (col_pos >= cols) ? cols - 1 : col_pos;
            row_end = (c == cols - 1);
            if (c == 0) row_first = v;
            if (!in_top_row) begin
                if (c > 0) add_quad(held, prev_row[c-1], prev_row[c], v);
                if (row_end) add_quad(v, prev_row[c], prev_row[0], row_first);
            end
            // line buffer lags one column; column 0 is refreshed at row end
            if (c >= 2) prev_row[c-1] = held;
            if (row_end) begin
                prev_row[c] = v;
                prev_row[0] = row_first;
                col_pos     = 0;
                in_top_row  = 1'b0;
            end else begin
                col_pos = c + 1;
            end
            held = v;
            if (expected_triangles.size() > base) expected_triangles[$].last_of_run = 1'b1;
        endfunction

        function void compare_field(string tag, logic [NUM_W-1:0] want, logic [NUM_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %h got %h", $time, tag, want, got);
            end
        endfunction

        function void check_triangle(gmt_pkg::t_out_item got);
            gmt_pkg::t_out_item want;
            if (expected_triangles.size() == 0) begin
                errors++;
                $display("%0t: triangle %h %h %h number %0d arrived with none expected",
                         $time, got.corner_a, got.corner_b, got.corner_c,
                         got.triangle_number);
                return;
            end
            want = expected_triangles.pop_front();
            checked++;
            compare_field("corner_a", NUM_W'(want.corner_a), NUM_W'(got.corner_a));
            compare_field("corner_b", NUM_W'(want.corner_b), NUM_W'(got.corner_b));
            compare_field("corner_c", NUM_W'(want.corner_c), NUM_W'(got.corner_c));
            compare_field("triangle_number", want.triangle_number, got.triangle_number);
            compare_field("last_of_run", NUM_W'(want.last_of_run), NUM_W'(got.last_of_run));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    gmt_pkg::t_in_item    in_item;
    logic                 out_valid;
    logic                 out_ready;
    gmt_pkg::t_out_item   out_item;

    triangle_scoreboard sb = new();

    bit            squeeze;
    int            burst_left;
    int unsigned   random_entries;
    int unsigned   entries_sent;
    int unsigned   cfg_writes;
    int unsigned   quiet;
    gmt_pkg::t_idx last_pick;

    grid_mesh_triangulator_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // 4 ns clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // handshake monitor and stall watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.set_row_length(cfg_data);
            if (in_valid && in_ready) sb.take_entry(in_item);
            if (out_valid && out_ready) sb.check_triangle(out_item);
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d triangles outstanding",
                         $time, quiet, sb.pending());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side: changing stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        int span;
        out_ready = 1'b0;
        mode      = 0;
        span      = 0;
        forever begin
            @(negedge clk);
            if (squeeze) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                squeeze = 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 80);
                end
                span--;
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = 1'($urandom_range(0, 1));
                    2: out_ready = (span % 3) != 0;
                    default: out_ready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // grid entry mix: mostly positive, some negative, zero, extreme and repeated
    function automatic gmt_pkg::t_idx pick_index();
        int unsigned   r;
        gmt_pkg::t_idx v;
        r = $urandom_range(0, 99);
        if (r < 68) begin
            v = gmt_pkg::t_idx'($urandom_range(1, 32767));
        end else if (r < 80) begin
            v = gmt_pkg::t_idx'(-int'($urandom_range(1, 32768)));
        end else if (r < 85) begin
            v = '0;
        end else if (r < 92) begin
            case ($urandom_range(0, 3))
                0: v = 16'sh7FFF;
                1: v = 16'sh8000;
                2: v = 16'sd1;
                default: v = -16'sd1;
            endcase
        end else begin
            v = last_pick;
        end
        last_pick = v;
        return v;
    endfunction

    // sender runs in bursts; called and returns at a falling edge
    task automatic send_entry(input gmt_pkg::t_idx v, input bit sg);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        in_item.vertex_index = v;
        in_item.start_grid   = sg;
        in_valid             = 1'b1;
        do @(posedge clk); while (!in_ready);
        entries_sent++;
        @(negedge clk);
    endtask

    // drain all triangles, then give the pipeline time to finish zero-result entries
    task automatic settle();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_row_length(input logic [CFG_W-1:0] len);
        cfg_data  = len;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    // one configuration phase; may resume the current grid when the row does not grow
    task automatic run_phase(input logic [CFG_W-1:0] len, input int unsigned rows,
                             input int squeeze_at, input bit counted);
        int unsigned cols;
        int unsigned total;
        bit          resume;
        bit          sg;
        cols   = sb.eff_cols(len);
        resume = !sb.in_top_row && cols <= sb.eff_cols(sb.row_len)
                 && $urandom_range(0, 2) == 0;
        settle();
        write_row_length(len);
        total = rows * cols + ((cols > 64) ? 0 : $urandom_range(0, cols - 1));
        for (int n = 0; n < total; n++) begin
            if (n == squeeze_at) squeeze = 1'b1;
            sg = (n == 0 && !resume) || (counted && $urandom_range(0, 39) == 0);
            send_entry(pick_index(), sg);
            if (counted) random_entries++;
        end
    endtask

    initial begin
        int phase;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_item        = '0;
        squeeze        = 1'b0;
        burst_left     = 0;
        random_entries = 0;
        entries_sent   = 0;
        cfg_writes     = 0;
        quiet          = 0;
        last_pick      = 16'sd1;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // default single column: entries are stored, nothing is emitted
        send_entry(16'sd5, 1'b1);
        send_entry(16'sd9, 1'b0);
        settle();
        write_row_length(CFG_W'(3));

        // three-wide grid with extreme, negative, zero and repeated entries
        send_entry(16'sd1, 1'b1);
        send_entry(16'sd2, 1'b0);
        send_entry(16'sd3, 1'b0);
        send_entry(16'sd4, 1'b0);
        send_entry(16'sd5, 1'b0);
        send_entry(16'sd6, 1'b0);
        send_entry(-16'sd32768, 1'b0);
        send_entry(-16'sd1, 1'b0);
        send_entry(16'sd32767, 1'b0);
        send_entry(16'sd0, 1'b0);
        send_entry(16'sd32767, 1'b0);
        send_entry(16'sd6, 1'b0);

        // start marker lands in the middle of a row
        send_entry(16'sd4, 1'b0);
        send_entry(16'sd7, 1'b1);
        send_entry(16'sd8, 1'b0);
        send_entry(16'sd9, 1'b0);
        send_entry(16'sd10, 1'b0);
        send_entry(16'sd11, 1'b0);
        send_entry(16'sd12, 1'b0);

        // row shrinks mid-row: column 2 is taken as the last column of a 2-wide row
        send_entry(16'sd13, 1'b0);
        send_entry(16'sd14, 1'b0);
        settle();
        write_row_length(CFG_W'(2));
        send_entry(16'sd15, 1'b0);
        send_entry(16'sd16, 1'b0);
        send_entry(16'sd17, 1'b0);

        // random phases: zero length, saturated length, a long hold-off, then narrow grids
        phase = 0;
        while (random_entries < RANDOM_TARGET) begin
            if (phase == 0) begin
                run_phase('0, 3, -1, 1'b1);
            end else if (phase == 2) begin
                // saturated length: part of a first row, no triangles yet
                settle();
                write_row_length('1);
                for (int n = 0; n < WIDE_ENTRIES; n++) send_entry(pick_index(), n == 0);
            end else if (phase == 3) begin
                run_phase(CFG_W'(8), 6, 12, 1'b1);
            end else if ($urandom_range(0, 5) == 0) begin
                run_phase(CFG_W'($urandom_range(13, 40)), 2, -1, 1'b1);
            end else begin
                run_phase(CFG_W'($urandom_range(1, 12)), $urandom_range(2, 5), -1, 1'b1);
            end
            phase++;
        end

        // drain and let any stray result show up
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Checked %0d triangles from %0d grid entries across %0d row-length writes,",
                 sb.checked, entries_sent, cfg_writes);
        $display("including lengths 0 and 2047 and a %0d-cycle result hold-off.", HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
